[hdl/clsr_pkg.sv]
`default_nettype none
package clsr_pkg;

    localparam longint IM1_L = 64'd2147483563;
    localparam logic [30:0] IM1 = 31'(IM1_L);
    localparam logic [30:0] IM2 = 31'd2147483399;
    localparam logic [15:0] IA1 = 16'd40014;
    localparam logic [15:0] IA2 = 16'd40692;
    // 2^31 minus each modulus, used to fold the high part of a product
    localparam logic [7:0] FOLD1 = 8'd85;
    localparam logic [7:0] FOLD2 = 8'd249;
    localparam int MAX_TRIES = 1024;
    localparam int TRIES_W = 11;

    typedef enum logic [1:0] {
        CMD_RESEED  = 2'd0,
        CMD_RAW     = 2'd1,
        CMD_BOUNDED = 2'd2,
        CMD_NONE    = 2'd3
    } clsr_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RS_MUL,
        ST_RS_RED,
        ST_MOD_BND,
        ST_GEN_DIV,
        ST_GEN_RD,
        ST_GEN_M2,
        ST_GEN_WB,
        ST_MOD_OUT
    } clsr_state_t;

    // (a*s) mod m for m = 2^31 - fold, given the 47-bit product a*s
    function automatic logic [30:0] lcg_reduce(input logic [46:0] p, input logic [7:0] fold,
                                               input logic [30:0] m);
        logic [31:0] sum;
        sum = 32'(p[30:0]) + 32'(p[46:31]) * 32'(fold);
        if (sum >= {1'b0, m})
        begin
            sum = sum - {1'b0, m};
        end
        return sum[30:0];
    endfunction

endpackage
`default_nettype wire

[hdl/combined_lcg_shuffle_rng.sv]
`default_nettype none
// A raw draw reads the shuffle table and steps both generators; a bounded draw first uses the divider
// for the rejection limit, repeats the draw for each rejected value and ends with a divider remainder;
// a reseed steps the first generator through its warm-up and then fills the shuffle table.
// Throughput: one word at a time; busy stays high until the shared multiplier, divider
// and table port finish. done pulses one cycle and the receiver cannot stall it.
// Reset clears the sequencer and partition offset; stream state is valid only after reseed.
module combined_lcg_shuffle_rng
    import clsr_pkg::*;
#(
    parameter int NUM_STREAMS = 4,
    parameter int TABLE_SIZE  = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  cmd,
    input  wire logic [1:0]  stream,
    input  wire logic [30:0] bound,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    output logic             done,
    output logic [30:0]      value,
    output logic [31:0]      step_count
);

    localparam int SW    = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
    localparam int TW    = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int DEPTH = NUM_STREAMS * TABLE_SIZE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int KW    = $clog2(TABLE_SIZE + 8);
    localparam logic [31:0] NDIV = 32'(64'd1 + (IM1_L - 64'd1) / longint'(TABLE_SIZE));

    clsr_state_t state_reg, state_next;
    logic        done_reg;
    logic [30:0] value_reg;
    logic [31:0] step_count_reg;
    logic [15:0] offset_reg;

    logic [30:0] fs_reg  [NUM_STREAMS];
    logic [30:0] ss_reg  [NUM_STREAMS];
    logic [30:0] lo_reg  [NUM_STREAMS];
    logic [31:0] cnt_reg [NUM_STREAMS];
    logic [30:0] tab_mem [DEPTH];

    logic [1:0]         cmd_reg;
    logic [SW-1:0]      st_reg;
    logic [30:0]        bd_reg;
    logic [30:0]        seed_reg;
    logic [KW-1:0]      k_reg;
    logic [30:0]        jrem_reg;
    logic [TW-1:0]      jq_reg;
    logic [TW-1:0]      jidx_reg;
    logic [30:0]        rd_reg;
    logic [30:0]        s1_reg;
    logic [46:0]        prod_reg;
    logic [30:0]        maxres_reg;
    logic [TRIES_W-1:0] tries_reg;

    logic [SW-1:0]      st_in;
    logic [30:0]        bd_in;
    logic [30:0]        seed_init;
    logic [15:0]        mul_a;
    logic [30:0]        mul_b;
    logic [30:0]        red1;
    logic [30:0]        red2;
    logic [TW-1:0]      jslot;
    logic [TW-1:0]      jsel;
    logic [30:0]        y;
    logic [TRIES_W-1:0] tries_inc;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;

    logic        div_start;
    logic [30:0] div_a;
    logic [30:0] div_b;
    logic        div_done;
    logic [30:0] div_rem;

    logic        fin;
    logic [30:0] fin_value;
    logic [31:0] fin_count;

    clsr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .rem      (div_rem)
    );

    // fold the stream number into range
    always_comb
    begin
        logic [6:0] t;
        t = 7'(stream);
        for (int i = 0; i < 3; i++)
        begin
            if (t >= 7'(NUM_STREAMS))
            begin
                t = t - 7'(NUM_STREAMS);
            end
        end
        st_in = SW'(t);
    end

    always_comb
    begin
        if (bound == '0)
        begin
            bd_in = 31'd1;
        end
        else if (bound > IM1)
        begin
            bd_in = IM1;
        end
        else
        begin
            bd_in = bound;
        end
        seed_init = 31'd13 + 31'(st_in) + 31'(NUM_STREAMS) * 31'(offset_reg);
    end

    always_comb
    begin
        case (state_reg)
            ST_RS_MUL:
            begin
                mul_a = IA1;
                mul_b = seed_reg;
            end
            ST_GEN_M2:
            begin
                mul_a = IA2;
                mul_b = ss_reg[st_reg];
            end
            default:
            begin
                mul_a = IA1;
                mul_b = fs_reg[st_reg];
            end
        endcase
    end

    // table slot of the last output: compare against every constant bucket edge at once
    always_comb
    begin
        jslot = '0;
        for (int k = 1; k < TABLE_SIZE; k++)
        begin
            if ({1'b0, jrem_reg} >= 32'(k) * NDIV)
            begin
                jslot = TW'(k);
            end
        end
    end

    always_comb
    begin
        red1    = lcg_reduce(prod_reg, FOLD1, IM1);
        red2    = lcg_reduce(prod_reg, FOLD2, IM2);
        jsel    = (jq_reg > TW'(TABLE_SIZE - 1)) ? TW'(TABLE_SIZE - 1) : jq_reg;
        if (rd_reg > red2)
        begin
            y = rd_reg - red2;
        end
        else
        begin
            y = 31'(32'(rd_reg) + 32'(IM1) - 32'd1 - 32'(red2));
        end
        tries_inc = tries_reg + TRIES_W'(1);
        rd_addr   = AW'(st_reg) * AW'(TABLE_SIZE) + AW'(jsel);
        if (state_reg == ST_RS_RED)
        begin
            wr_addr = AW'(st_reg) * AW'(TABLE_SIZE) + AW'(k_reg[TW-1:0]);
        end
        else
        begin
            wr_addr = AW'(st_reg) * AW'(TABLE_SIZE) + AW'(jidx_reg);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        div_a      = IM1;
        div_b      = bd_in;
        fin        = 1'b0;
        fin_value  = '0;
        fin_count  = cnt_reg[st_reg];
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (cmd)
                        CMD_RESEED:
                        begin
                            state_next = ST_RS_MUL;
                        end
                        CMD_RAW:
                        begin
                            state_next = ST_GEN_DIV;
                        end
                        CMD_BOUNDED:
                        begin
                            div_start  = 1'b1;
                            state_next = ST_MOD_BND;
                        end
                        default:
                        begin
                            fin       = 1'b1;
                            fin_count = cnt_reg[st_in];
                        end
                    endcase
                end
            end
            ST_RS_MUL:
            begin
                state_next = ST_RS_RED;
            end
            ST_RS_RED:
            begin
                if (k_reg == '0)
                begin
                    fin        = 1'b1;
                    fin_count  = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_RS_MUL;
                end
            end
            ST_MOD_BND:
            begin
                if (div_done)
                begin
                    state_next = ST_GEN_DIV;
                end
            end
            ST_GEN_DIV:
            begin
                state_next = ST_GEN_RD;
            end
            ST_GEN_RD:
            begin
                state_next = ST_GEN_M2;
            end
            ST_GEN_M2:
            begin
                state_next = ST_GEN_WB;
            end
            ST_GEN_WB:
            begin
                if (cmd_reg == CMD_RAW)
                begin
                    fin        = 1'b1;
                    fin_value  = y;
                    fin_count  = cnt_reg[st_reg] + 32'd1;
                    state_next = ST_IDLE;
                end
                else if (y > maxres_reg && tries_inc < TRIES_W'(MAX_TRIES))
                begin
                    state_next = ST_GEN_DIV;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_a      = y - 31'd1;
                    div_b      = bd_reg;
                    state_next = ST_MOD_OUT;
                end
            end
            ST_MOD_OUT:
            begin
                if (div_done)
                begin
                    fin        = 1'b1;
                    fin_value  = div_rem;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            done_reg   <= 1'b0;
            offset_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= fin;
            if (cfg_we)
            begin
                offset_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin)
        begin
            value_reg      <= fin_value;
            step_count_reg <= fin_count;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_reg   <= cmd;
                    st_reg    <= st_in;
                    bd_reg    <= bd_in;
                    seed_reg  <= seed_init;
                    k_reg     <= KW'(TABLE_SIZE + 7);
                    jrem_reg  <= lo_reg[st_in];
                    jq_reg    <= '0;
                    tries_reg <= '0;
                    if (cmd == CMD_RESEED)
                    begin
                        ss_reg[st_in] <= seed_init;
                    end
                end
            end
            ST_RS_MUL:
            begin
                prod_reg <= 47'(mul_a) * 47'(mul_b);
            end
            ST_RS_RED:
            begin
                seed_reg <= red1;
                k_reg    <= k_reg - KW'(1);
                if (k_reg < KW'(TABLE_SIZE))
                begin
                    tab_mem[wr_addr] <= red1;
                end
                if (k_reg == '0)
                begin
                    fs_reg[st_reg]  <= red1;
                    lo_reg[st_reg]  <= red1;
                    cnt_reg[st_reg] <= '0;
                end
            end
            ST_MOD_BND:
            begin
                if (div_done)
                begin
                    maxres_reg <= IM1 - div_rem - 31'd2;
                end
            end
            ST_GEN_DIV:
            begin
                jq_reg <= jslot;
            end
            ST_GEN_RD:
            begin
                rd_reg   <= tab_mem[rd_addr];
                prod_reg <= 47'(mul_a) * 47'(mul_b);
                jidx_reg <= jsel;
            end
            ST_GEN_M2:
            begin
                s1_reg   <= red1;
                prod_reg <= 47'(mul_a) * 47'(mul_b);
            end
            ST_GEN_WB:
            begin
                tab_mem[wr_addr] <= s1_reg;
                fs_reg[st_reg]   <= s1_reg;
                ss_reg[st_reg]   <= red2;
                lo_reg[st_reg]   <= y;
                cnt_reg[st_reg]  <= cnt_reg[st_reg] + 32'd1;
                tries_reg        <= tries_inc;
                jrem_reg         <= y;
                jq_reg           <= '0;
            end
            default:
            begin
            end
        endcase
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign value      = value_reg;
    assign step_count = step_count_reg;

endmodule
`default_nettype wire

[hdl/clsr_div.sv]
`default_nettype none
module clsr_div
    import clsr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [30:0] dividend,
    input  wire logic [30:0] divisor,
    output logic             done,
    output logic [30:0]      rem
);

    logic [4:0]  cnt_reg;
    logic        done_reg;
    logic [31:0] rem_reg;
    logic [30:0] num_reg;
    logic [30:0] den_reg;
    logic [31:0] trial;
    logic        fits;

    always_comb
    begin
        trial = {rem_reg[30:0], num_reg[30]};
        fits  = trial >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == 5'd1);
            if (start)
            begin
                cnt_reg <= 5'd31;
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 5'd1;
            end
        end
    end

    // one dividend bit a cycle, MSB first
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            num_reg <= dividend;
            den_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= fits ? (trial - {1'b0, den_reg}) : trial;
            num_reg <= {num_reg[29:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg[30:0];

endmodule
`default_nettype wire

[hdl/clsr_chk.sv]
`default_nettype none
module clsr_chk
    import clsr_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [30:0] value
);

    // a word is shown only once the block is free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("done while busy");

    a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted command neither runs nor finishes");

    a_busy_ends_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (value < IM1))
        else $error("value out of range");

endmodule

bind combined_lcg_shuffle_rng clsr_chk u_clsr_chk (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .value (value)
);
`default_nettype wire
